// ===== rtl/wrsh_pkg.sv =====
// shared types, constants and the weight table of the route selector
`default_nettype none

package wrsh_pkg;

   localparam int NUM_METRICS = 6;
   localparam int METRIC_W    = 8;
   localparam int WEIGHT_W    = 3;
   localparam int SCORE_W     = 11;
   localparam int PRODUCT_W   = METRIC_W + WEIGHT_W - 1;
   localparam int KIND_W      = 8;
   localparam int INTENT_W    = 3;
   localparam int PAYLOAD_W   = 32;
   localparam int MARGIN_W    = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [METRIC_W-1:0]  METRIC_CAP  = 8'd100;
   localparam logic [PAYLOAD_W-1:0] BULK_BYTES  = 32'd1024;
   localparam logic [SCORE_W-1:0]   BULK_ADJUST = 11'd250;

   // intent codes
   localparam logic [INTENT_W-1:0] INTENT_RELIABLE  = 3'd0;
   localparam logic [INTENT_W-1:0] INTENT_FAST      = 3'd1;
   localparam logic [INTENT_W-1:0] INTENT_LOW_POWER = 3'd2;
   localparam logic [INTENT_W-1:0] INTENT_CRITICAL  = 3'd3;
   localparam logic [INTENT_W-1:0] INTENT_BULK      = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HAS_CURRENT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_KIND  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWITCH_MARGIN = 2'd2;

   typedef logic [NUM_METRICS-1:0][METRIC_W-1:0] metric_vec_type;
   typedef logic [NUM_METRICS-1:0][WEIGHT_W-1:0] weight_vec_type;

   // one candidate on its way through the scoring cells
   typedef struct packed {
      logic                available;
      logic                last;
      logic [KIND_W-1:0]   kind;
      metric_vec_type      metrics;
      weight_vec_type      weights;
      logic [SCORE_W-1:0]  sum;
   } beat_type;

   // top-two ranking and current link tally
   typedef struct packed {
      logic               best_valid;
      logic [SCORE_W-1:0] best_score;
      logic [KIND_W-1:0]  best_kind;
      logic               second_valid;
      logic [SCORE_W-1:0] second_score;
      logic [KIND_W-1:0]  second_kind;
      logic               cur_found;
      logic [SCORE_W-1:0] cur_score;
      logic               cur_is_best;
   } tally_type;

   // element 0 is reliability, element 5 confidence
   function automatic weight_vec_type weight_row(input logic [INTENT_W-1:0] intent);
      weight_vec_type row;
      unique case (intent)
         INTENT_FAST:      row = {3'd2, 3'd1, 3'd1, 3'd4, 3'd4, 3'd2};
         INTENT_LOW_POWER: row = {3'd2, 3'd3, 3'd5, 3'd1, 3'd1, 3'd2};
         INTENT_CRITICAL:  row = {3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd5};
         INTENT_BULK:      row = {3'd2, 3'd2, 3'd1, 3'd5, 3'd2, 3'd2};
         default:          row = {3'd3, 3'd1, 3'd1, 3'd1, 3'd1, 3'd4};
      endcase
      return row;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/wrsh_cell.sv =====
// one scoring cell: adds one clamped, weighted metric and hands the beat on
`default_nettype none

module wrsh_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire wrsh_pkg::beat_type  in_beat,
   output logic                     in_ready,
   output logic                     out_valid,
   output wrsh_pkg::beat_type       out_beat,
   input  wire logic                out_ready
);

   logic                           valid_ff;
   logic                           valid_in;
   wrsh_pkg::beat_type             beat_ff;
   wrsh_pkg::beat_type             beat_in;
   logic [wrsh_pkg::METRIC_W-1:0]  metric_clamped;
   logic [wrsh_pkg::PRODUCT_W-1:0] product;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      metric_clamped = (in_beat.metrics[0] > wrsh_pkg::METRIC_CAP) ?
                       wrsh_pkg::METRIC_CAP : in_beat.metrics[0];
      product = wrsh_pkg::PRODUCT_W'(metric_clamped) *
                wrsh_pkg::PRODUCT_W'(in_beat.weights[0]);
      beat_in         = in_beat;
      // next cell always works on element 0
      beat_in.metrics = in_beat.metrics >> wrsh_pkg::METRIC_W;
      beat_in.weights = in_beat.weights >> wrsh_pkg::WEIGHT_W;
      beat_in.sum     = in_beat.sum + wrsh_pkg::SCORE_W'(product);
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

`default_nettype wire

// ===== rtl/wrsh_rank.sv =====
// best and second-best ranking with current link tracking, cleared per batch
`default_nettype none

module wrsh_rank (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire wrsh_pkg::beat_type          in_beat,
   output logic                             in_ready,
   input  wire logic                        has_current,
   input  wire logic [wrsh_pkg::KIND_W-1:0] current_kind,
   input  wire logic                        fin_free,
   output logic                             fin_load,
   output wrsh_pkg::tally_type              fin_tally
);

   wrsh_pkg::tally_type           tally_ff;
   wrsh_pkg::tally_type           tally_in;
   wrsh_pkg::tally_type           upd;
   logic [wrsh_pkg::SCORE_W-1:0]  score;
   logic                          cur_hit;
   logic                          above_best;
   logic                          above_second;
   logic                          take;

   // only the closing beat of a batch needs room in the finish stage
   assign in_ready = !in_beat.last || fin_free;
   assign take     = in_valid && in_ready;

   always_comb begin
      // sum carries a bias of one bulk adjustment; remove it and clamp at zero
      score = (in_beat.sum >= wrsh_pkg::BULK_ADJUST) ?
              in_beat.sum - wrsh_pkg::BULK_ADJUST : '0;
      cur_hit = has_current && (in_beat.kind == current_kind);
      above_best = (score > tally_ff.best_score) ||
                   ((score == tally_ff.best_score) && (in_beat.kind < tally_ff.best_kind));
      above_second = (score > tally_ff.second_score) ||
                     ((score == tally_ff.second_score) &&
                      (in_beat.kind < tally_ff.second_kind));
      upd = tally_ff;
      if (in_beat.available) begin
         if (!tally_ff.best_valid || above_best) begin
            if (tally_ff.best_valid) begin
               upd.second_valid = 1'b1;
               upd.second_score = tally_ff.best_score;
               upd.second_kind  = tally_ff.best_kind;
            end
            upd.best_valid  = 1'b1;
            upd.best_score  = score;
            upd.best_kind   = in_beat.kind;
            upd.cur_is_best = cur_hit;
         end else begin
            if (cur_hit) begin
               upd.cur_is_best = 1'b0;
            end
            if (!tally_ff.second_valid || above_second) begin
               upd.second_valid = 1'b1;
               upd.second_score = score;
               upd.second_kind  = in_beat.kind;
            end
         end
         if (cur_hit) begin
            upd.cur_found = 1'b1;
            upd.cur_score = score;
         end
      end
   end

   always_comb begin
      tally_in = tally_ff;
      if (take) begin
         tally_in = in_beat.last ? '0 : upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff <= '0;
      end else begin
         tally_ff <= tally_in;
      end
   end

   assign fin_load  = take && in_beat.last;
   assign fin_tally = upd;

endmodule

`default_nettype wire

// ===== rtl/weighted_route_selector_hysteresis_core.sv =====
// top level: scoring cell chain, ranking, hysteresis pick and result register
`default_nettype none

// Takes one candidate link per cycle while req_stall is low, and gives one
// result beat for each batch, on the candidate marked last. A candidate
// walks through a row of six registered scoring cells, each adding one
// clamped metric times its intent weight; the ranking stage then folds it
// into the registered best/second-best tally, which is what lets it take
// one candidate per clock. After the last candidate is taken, it passes
// five more cells, ranking loads the finish stage and the hysteresis pick
// loads the output register. Stalls on the result side hold nothing back
// until a candidate marked last reaches the ranking stage while the finish
// stage still holds a tally that the output register cannot take; that
// candidate then waits there and the cells behind it wait with it.
// Registers are to be written only while no batch is in flight.
module weighted_route_selector_hysteresis_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wen,
   input  wire logic [wrsh_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [wrsh_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_reliability,
   input  wire logic [7:0]                        req_latency_quality,
   input  wire logic [7:0]                        req_throughput,
   input  wire logic [7:0]                        req_energy_efficiency,
   input  wire logic [7:0]                        req_airtime_efficiency,
   input  wire logic [7:0]                        req_confidence,
   input  wire logic                              req_available,
   input  wire logic                              req_bulk_capable,
   input  wire logic [7:0]                        req_candidate_kind,
   input  wire logic [2:0]                        req_intent,
   input  wire logic [31:0]                       req_payload_bytes,
   input  wire logic                              req_last,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_has_primary,
   output logic [7:0]                             rsp_primary_kind,
   output logic [10:0]                            rsp_primary_score,
   output logic                                   rsp_has_backup,
   output logic [7:0]                             rsp_backup_kind,
   output logic [10:0]                            rsp_backup_score
);

   localparam int NUM_CELLS = wrsh_pkg::NUM_METRICS;
   localparam int MARGIN_SUM_W = wrsh_pkg::MARGIN_W + 1;

   // configuration registers
   logic                            has_current_ff;
   logic                            has_current_in;
   logic [wrsh_pkg::KIND_W-1:0]     current_kind_ff;
   logic [wrsh_pkg::KIND_W-1:0]     current_kind_in;
   logic [wrsh_pkg::MARGIN_W-1:0]   margin_ff;
   logic [wrsh_pkg::MARGIN_W-1:0]   margin_in;

   always_comb begin
      has_current_in  = has_current_ff;
      current_kind_in = current_kind_ff;
      margin_in       = margin_ff;
      if (csr_wen) begin
         unique case (csr_index)
            wrsh_pkg::CSR_HAS_CURRENT:   has_current_in  = csr_wdata[0];
            wrsh_pkg::CSR_CURRENT_KIND:  current_kind_in = csr_wdata[wrsh_pkg::KIND_W-1:0];
            wrsh_pkg::CSR_SWITCH_MARGIN: margin_in       = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_current_ff  <= 1'b0;
         current_kind_ff <= '0;
         margin_ff       <= '0;
      end else begin
         has_current_ff  <= has_current_in;
         current_kind_ff <= current_kind_in;
         margin_ff       <= margin_in;
      end
   end

   // entry beat: weight row lookup and bulk adjustment folded into the start sum
   wrsh_pkg::beat_type entry_beat;
   logic               bulk;

   always_comb begin
      bulk = (req_intent == wrsh_pkg::INTENT_BULK) ||
             (req_payload_bytes >= wrsh_pkg::BULK_BYTES);
      entry_beat.available = req_available;
      entry_beat.last      = req_last;
      entry_beat.kind      = req_candidate_kind;
      entry_beat.metrics   = {req_confidence, req_airtime_efficiency,
                              req_energy_efficiency, req_throughput,
                              req_latency_quality, req_reliability};
      entry_beat.weights   = wrsh_pkg::weight_row(req_intent);
      // biased by one adjustment so a penalty never goes below zero
      if (!bulk) begin
         entry_beat.sum = wrsh_pkg::BULK_ADJUST;
      end else if (req_bulk_capable) begin
         entry_beat.sum = wrsh_pkg::BULK_ADJUST + wrsh_pkg::BULK_ADJUST;
      end else begin
         entry_beat.sum = '0;
      end
   end

   // scoring cell chain
   wrsh_pkg::beat_type chain_beat  [NUM_CELLS+1];
   logic               chain_valid [NUM_CELLS+1];
   logic               chain_ready [NUM_CELLS+1];

   assign chain_beat[0]  = entry_beat;
   assign chain_valid[0] = req_valid;
   assign req_stall      = !chain_ready[0];

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      wrsh_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_beat   (chain_beat[g]),
         .in_ready  (chain_ready[g]),
         .out_valid (chain_valid[g+1]),
         .out_beat  (chain_beat[g+1]),
         .out_ready (chain_ready[g+1])
      );
   end

   // ranking
   logic                fin_valid_ff;
   logic                fin_valid_in;
   wrsh_pkg::tally_type fin_tally_ff;
   wrsh_pkg::tally_type fin_tally;
   logic                fin_free;
   logic                fin_load;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_free;

   wrsh_rank u_rank (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (chain_valid[NUM_CELLS]),
      .in_beat      (chain_beat[NUM_CELLS]),
      .in_ready     (chain_ready[NUM_CELLS]),
      .has_current  (has_current_ff),
      .current_kind (current_kind_ff),
      .fin_free     (fin_free),
      .fin_load     (fin_load),
      .fin_tally    (fin_tally)
   );

   // finish stage holds the closing tally of a batch
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign fin_free     = !fin_valid_ff || rsp_free;
   assign fin_valid_in = fin_load || (fin_valid_ff && !rsp_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_load) begin
         fin_tally_ff <= fin_tally;
      end
   end

   // hysteresis pick
   logic [MARGIN_SUM_W-1:0] cur_plus_margin;
   logic                    keep_current;
   logic                    has_primary_in;
   logic [7:0]              primary_kind_in;
   logic [10:0]             primary_score_in;
   logic                    has_backup_in;
   logic [7:0]              backup_kind_in;
   logic [10:0]             backup_score_in;

   always_comb begin
      cur_plus_margin = MARGIN_SUM_W'(fin_tally_ff.cur_score) + MARGIN_SUM_W'(margin_ff);
      keep_current = fin_tally_ff.cur_found && !fin_tally_ff.cur_is_best &&
                     (MARGIN_SUM_W'(fin_tally_ff.best_score) < cur_plus_margin);
      has_primary_in   = 1'b0;
      primary_kind_in  = '0;
      primary_score_in = '0;
      has_backup_in    = 1'b0;
      backup_kind_in   = '0;
      backup_score_in  = '0;
      if (fin_tally_ff.best_valid) begin
         has_primary_in = 1'b1;
         if (keep_current) begin
            primary_kind_in  = current_kind_ff;
            primary_score_in = fin_tally_ff.cur_score;
            has_backup_in    = 1'b1;
            backup_kind_in   = fin_tally_ff.best_kind;
            backup_score_in  = fin_tally_ff.best_score;
         end else begin
            primary_kind_in  = fin_tally_ff.best_kind;
            primary_score_in = fin_tally_ff.best_score;
            if (fin_tally_ff.second_valid) begin
               has_backup_in   = 1'b1;
               backup_kind_in  = fin_tally_ff.second_kind;
               backup_score_in = fin_tally_ff.second_score;
            end
         end
      end
   end

   // result register
   logic        has_primary_ff;
   logic [7:0]  primary_kind_ff;
   logic [10:0] primary_score_ff;
   logic        has_backup_ff;
   logic [7:0]  backup_kind_ff;
   logic [10:0] backup_score_ff;
   logic        rsp_load;

   assign rsp_load     = fin_valid_ff && rsp_free;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         has_primary_ff   <= has_primary_in;
         primary_kind_ff  <= primary_kind_in;
         primary_score_ff <= primary_score_in;
         has_backup_ff    <= has_backup_in;
         backup_kind_ff   <= backup_kind_in;
         backup_score_ff  <= backup_score_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_has_primary   = has_primary_ff;
   assign rsp_primary_kind  = primary_kind_ff;
   assign rsp_primary_score = primary_score_ff;
   assign rsp_has_backup    = has_backup_ff;
   assign rsp_backup_kind   = backup_kind_ff;
   assign rsp_backup_score  = backup_score_ff;

`ifndef SYNTHESIS
   a_fin_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      fin_load |-> (!fin_valid_ff || rsp_free))
      else $error("finish stage loaded while holding an undelivered tally");

   a_empty_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_primary) |->
         (rsp_primary_kind == 8'd0 && rsp_primary_score == 11'd0 && !rsp_has_backup))
      else $error("result without primary carries nonzero fields");

   a_backup_needs_primary: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_backup) |-> rsp_has_primary)
      else $error("backup reported without a primary");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fin_valid_ff))
      else $error("result raised without a finished tally");
`endif

endmodule

`default_nettype wire
